### hdl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Shared constants and result codes of the buddy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int unsigned MEM_ORDER  = 20;
  localparam int unsigned MIN_ORDER  = 4;
  localparam int unsigned NUM_ORDERS = MEM_ORDER - MIN_ORDER + 1;
  localparam int unsigned MAP_BITS   = 1 << NUM_ORDERS;
  localparam int unsigned MAP_WORDS  = MAP_BITS / 64;
  localparam int unsigned POS_W      = NUM_ORDERS;
  localparam int unsigned WORD_AW    = POS_W - 6;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NO_BLOCK  = 2'd1,
    ST_TOO_LARGE = 2'd2
  } status_e;

endpackage

`default_nettype wire

### hdl/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// Buddy block allocator
// Binary buddy allocator over a 1 MiB pool with per-order free bitmaps.
// ----------------------------------------------------------------------------
// After reset the block clears all 2048 words of the bitmap memory before it
// takes its first request. The free bitmap of every order lives in one 2048 x
// 64 bit memory that is read one word per cycle. An allocation scans that
// memory upward from the requested order, one word per cycle (up to 2048 words
// when the pool is nearly empty or fragmented), then reads and writes a bitmap
// word per split; a free request reads the block's bit to check it, reads the
// buddy at each merge level, at most sixteen levels, and then marks the merged
// block free. One request is processed at a time; a finished result waits in
// the output register while the next request is taken.
`default_nettype none

module buddy_block_allocator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // size_bytes [20:0], block_address [40:21], zero [47:41]
  input  wire logic [47:0] s_axis_tdata_i,
  // command [0]
  input  wire logic        s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // granted_address [19:0], status [21:20], zero [23:22]
  output logic [23:0]      m_axis_tdata_o
);

  localparam int unsigned PW = bba_pkg::POS_W;
  localparam int unsigned AW = bba_pkg::WORD_AW;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SCAN0, S_SCAN, S_DEC, S_OP_RD, S_OP_WR,
    S_CHK_RD, S_CHK, S_BUD_RD, S_BUD, S_DONE
  } state_e;

  function automatic logic [PW-1:0] pos_of(input logic [4:0] o, input logic [19:0] a);
    logic [PW:0] b;
    b = (PW+1)'(bba_pkg::MAP_BITS) - ((PW+1)'(1) << (5'(bba_pkg::MEM_ORDER + 1) - o));
    return b[PW-1:0] + PW'(a >> o);
  endfunction

  logic [63:0] mem_q [bba_pkg::MAP_WORDS];
  logic [63:0] rdata_q;

  state_e            state_q;
  logic [AW-1:0]     clr_q;
  logic [AW-1:0]     scan_w_q;
  logic [5:0]        lo_q;
  logic [PW-1:0]     pos_q;
  logic              val_q;
  logic              alloc_q;
  logic [4:0]        ord_q;
  logic [4:0]        cur_q;
  logic [19:0]       addr_q;
  logic [19:0]       res_addr_q;
  bba_pkg::status_e  res_st_q;
  logic              out_valid_q;
  logic [19:0]       out_addr_q;
  bba_pkg::status_e  out_st_q;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              we;
  logic [AW-1:0]     wr_addr;
  logic [63:0]       wr_data;

  logic [20:0]       size_in;
  logic [20:0]       size_m1;
  logic [4:0]        req_ord;
  logic [PW-1:0]     scan_pos;
  logic [63:0]       masked;
  logic [5:0]        first_bit;
  logic [PW-1:0]     rpos;
  logic [4:0]        msb_r;
  logic [4:0]        dec_ord;
  logic [PW-1:0]     dec_idx;
  logic [19:0]       dec_addr;
  logic              bit_set;
  logic [4:0]        m_ord;
  logic [19:0]       m_addr;
  logic [19:0]       free_addr;

  assign size_in = s_axis_tdata_i[20:0];
  assign size_m1 = size_in - 21'd1;

  always_comb begin
    req_ord = 5'(bba_pkg::MIN_ORDER);
    if (size_in > (21'd1 << bba_pkg::MIN_ORDER)) begin
      for (int i = 0; i < 21; i++) begin
        if (size_m1[i]) req_ord = 5'(i + 1);
      end
    end
  end

  assign scan_pos  = pos_of(req_ord, 20'd0);
  assign free_addr = s_axis_tdata_i[40:21] & (20'hFFFFF << req_ord);

  assign masked = rdata_q & ({64{1'b1}} << lo_q);

  always_comb begin
    first_bit = '0;
    for (int i = 63; i >= 0; i--) begin
      if (masked[i]) first_bit = 6'(i);
    end
  end

  assign rpos = ~pos_q;

  always_comb begin
    msb_r = '0;
    for (int i = 0; i < PW; i++) begin
      if (rpos[i]) msb_r = 5'(i);
    end
  end

  assign dec_ord  = 5'(bba_pkg::MEM_ORDER) - msb_r;
  assign dec_idx  = pos_q - pos_of(dec_ord, 20'd0);
  assign dec_addr = 20'({{(20 - PW){1'b0}}, dec_idx} << dec_ord);
  assign bit_set  = rdata_q[pos_q[5:0]];

  always_comb begin
    if (state_q == S_BUD) begin
      m_ord  = ord_q + 5'd1;
      m_addr = addr_q & ~(20'd1 << ord_q);
    end else begin
      m_ord  = ord_q;
      m_addr = addr_q;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pos_q[PW-1:6];
    we      = 1'b0;
    wr_addr = pos_q[PW-1:6];
    wr_data = (rdata_q & ~(64'd1 << pos_q[5:0])) | (64'(val_q) << pos_q[5:0]);
    unique case (state_q)
      S_CLR: begin
        we      = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
      end
      S_SCAN0: begin
        rd_en   = 1'b1;
        rd_addr = scan_w_q;
      end
      S_SCAN: begin
        rd_addr = scan_w_q + AW'(1);
        rd_en   = !(|masked) && (scan_w_q != {AW{1'b1}});
      end
      S_OP_RD, S_CHK_RD, S_BUD_RD: rd_en = 1'b1;
      S_OP_WR: we = 1'b1;
      S_BUD: we = bit_set;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == {AW{1'b1}}) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            alloc_q    <= !s_axis_tuser_i;
            ord_q      <= req_ord;
            res_addr_q <= '0;
            res_st_q   <= bba_pkg::ST_DONE;
            if (!s_axis_tuser_i) begin
              if (req_ord >= 5'(bba_pkg::MEM_ORDER - 1)) begin
                res_st_q <= bba_pkg::ST_TOO_LARGE;
                state_q  <= S_DONE;
              end else begin
                scan_w_q <= scan_pos[PW-1:6];
                lo_q     <= scan_pos[5:0];
                state_q  <= S_SCAN0;
              end
            end else if (req_ord > 5'(bba_pkg::MEM_ORDER)) begin
              res_st_q <= bba_pkg::ST_TOO_LARGE;
              state_q  <= S_DONE;
            end else begin
              addr_q  <= free_addr;
              pos_q   <= pos_of(req_ord, free_addr);
              state_q <= S_CHK_RD;
            end
          end
        end
        S_SCAN0: state_q <= S_SCAN;
        S_SCAN: begin
          if (|masked) begin
            pos_q   <= {scan_w_q, first_bit};
            state_q <= S_DEC;
          end else if (scan_w_q == {AW{1'b1}}) begin
            res_st_q <= bba_pkg::ST_NO_BLOCK;
            state_q  <= S_DONE;
          end else begin
            scan_w_q <= scan_w_q + AW'(1);
            lo_q     <= '0;
          end
        end
        S_DEC: begin
          cur_q   <= dec_ord;
          addr_q  <= dec_addr;
          val_q   <= 1'b0;
          state_q <= S_OP_RD;
        end
        S_OP_RD: state_q <= S_OP_WR;
        S_OP_WR: begin
          if (alloc_q && (cur_q > ord_q)) begin
            pos_q   <= pos_of(cur_q - 5'd1, addr_q | (20'd1 << (cur_q - 5'd1)));
            val_q   <= 1'b1;
            cur_q   <= cur_q - 5'd1;
            state_q <= S_OP_RD;
          end else begin
            if (alloc_q) res_addr_q <= addr_q;
            state_q <= S_DONE;
          end
        end
        S_CHK_RD: state_q <= S_CHK;
        S_BUD_RD: state_q <= S_BUD;
        S_CHK, S_BUD: begin
          if (state_q == S_CHK && bit_set) begin
            state_q <= S_DONE;
          end else if (state_q == S_BUD && !bit_set) begin
            pos_q   <= pos_of(ord_q, addr_q);
            val_q   <= 1'b1;
            state_q <= S_OP_RD;
          end else begin
            ord_q  <= m_ord;
            addr_q <= m_addr;
            if (m_ord < 5'(bba_pkg::MEM_ORDER)) begin
              pos_q   <= pos_of(m_ord, m_addr ^ (20'd1 << m_ord));
              val_q   <= 1'b0;
              state_q <= S_BUD_RD;
            end else begin
              pos_q   <= pos_of(m_ord, m_addr);
              val_q   <= 1'b1;
              state_q <= S_OP_RD;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            out_addr_q  <= res_addr_q;
            out_st_q    <= res_st_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_st_q, out_addr_q};

endmodule

`default_nettype wire

### hdl/bba_checker.sv
// ----------------------------------------------------------------------------
// Buddy block allocator checker
// Port-level assertions on the allocator's request and result streams.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [23:0] m_axis_tdata_o
);

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("request taken while another was in progress");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[21:20] == bba_pkg::ST_DONE ||
                         m_axis_tdata_o[21:20] == bba_pkg::ST_NO_BLOCK ||
                         m_axis_tdata_o[21:20] == bba_pkg::ST_TOO_LARGE))
    else $error("undefined status code");

  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[21:20] != bba_pkg::ST_DONE) |->
      (m_axis_tdata_o[19:0] == 20'd0))
    else $error("failed request returned an address");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
